// ----- hw/rtl/sdbs_pkg.sv -----
// ----------------------------------------------------------------------------
// sdbs_pkg
// Shared types, constants and the microcode program of the sort, dedup and
// binary search core.
// ----------------------------------------------------------------------------
`default_nettype none

package sdbs_pkg;

    // Store geometry
    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths of the item formats
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int UNIQ_W  = 5;

    // Step counter width of the sequencer
    localparam int STEP_W  = 4;

    // Input opcodes and result kinds
    localparam logic OPC_LOAD    = 1'b0;
    localparam logic OPC_SEARCH  = 1'b1;
    localparam logic KIND_SET    = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic                       opcode;
        logic signed [VALUE_W-1:0]  data_value;
        logic                       last_of_set;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [UNIQ_W-1:0] unique_count;
        logic              overflowed;
    } out_item_t;

    // Datapath actions, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_LOAD,
        OP_SORT_INIT,
        OP_PASS_START,
        OP_PASS_X,
        OP_BUBBLE,
        OP_PASS_END,
        OP_DD_INIT,
        OP_DD_STEP,
        OP_SET_DONE,
        OP_EMIT_SET,
        OP_SR_INIT,
        OP_SR_PROBE,
        OP_SR_CMP,
        OP_EMIT_SR
    } dp_op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IS_SEARCH,
        C_NOT_LAST,
        C_P_LE1,
        C_MORE_PAIRS,
        C_DD_MORE,
        C_SR_EMPTY,
        C_NOT_HIT
    } cond_t;

    // Program step addresses
    localparam logic [STEP_W-1:0] S_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH  = 4'd1;
    localparam logic [STEP_W-1:0] S_LOAD      = 4'd2;
    localparam logic [STEP_W-1:0] S_SORT_INIT = 4'd3;
    localparam logic [STEP_W-1:0] S_PASS_TOP  = 4'd4;
    localparam logic [STEP_W-1:0] S_PASS_X    = 4'd5;
    localparam logic [STEP_W-1:0] S_BUBBLE    = 4'd6;
    localparam logic [STEP_W-1:0] S_PASS_END  = 4'd7;
    localparam logic [STEP_W-1:0] S_DD_INIT   = 4'd8;
    localparam logic [STEP_W-1:0] S_DD_STEP   = 4'd9;
    localparam logic [STEP_W-1:0] S_DD_END    = 4'd10;
    localparam logic [STEP_W-1:0] S_EMIT_SET  = 4'd11;
    localparam logic [STEP_W-1:0] S_SR_INIT   = 4'd12;
    localparam logic [STEP_W-1:0] S_SR_PROBE  = 4'd13;
    localparam logic [STEP_W-1:0] S_SR_CMP    = 4'd14;
    localparam logic [STEP_W-1:0] S_EMIT_SR   = 4'd15;

    typedef struct packed {
        dp_op_t             op;
        cond_t              cond;
        logic [STEP_W-1:0]  target;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        dp_op_t op;
        logic   en;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic is_search;
        logic not_last;
        logic p_le1;
        logic more_pairs;
        logic dd_more;
        logic sr_empty;
        logic not_hit;
        logic out_busy;
    } status_t;

    // Microcode program: action, jump condition, jump target
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            S_IDLE:      w = '{OP_ACCEPT,     C_NEVER,      S_IDLE};
            S_DISPATCH:  w = '{OP_NOP,        C_IS_SEARCH,  S_SR_INIT};
            S_LOAD:      w = '{OP_LOAD,       C_NOT_LAST,   S_IDLE};
            S_SORT_INIT: w = '{OP_SORT_INIT,  C_NEVER,      S_IDLE};
            S_PASS_TOP:  w = '{OP_PASS_START, C_P_LE1,      S_DD_INIT};
            S_PASS_X:    w = '{OP_PASS_X,     C_NEVER,      S_IDLE};
            S_BUBBLE:    w = '{OP_BUBBLE,     C_MORE_PAIRS, S_BUBBLE};
            S_PASS_END:  w = '{OP_PASS_END,   C_ALWAYS,     S_PASS_TOP};
            S_DD_INIT:   w = '{OP_DD_INIT,    C_NEVER,      S_IDLE};
            S_DD_STEP:   w = '{OP_DD_STEP,    C_DD_MORE,    S_DD_STEP};
            S_DD_END:    w = '{OP_SET_DONE,   C_NEVER,      S_IDLE};
            S_EMIT_SET:  w = '{OP_EMIT_SET,   C_ALWAYS,     S_IDLE};
            S_SR_INIT:   w = '{OP_SR_INIT,    C_NEVER,      S_IDLE};
            S_SR_PROBE:  w = '{OP_SR_PROBE,   C_SR_EMPTY,   S_EMIT_SR};
            S_SR_CMP:    w = '{OP_SR_CMP,     C_NOT_HIT,    S_SR_PROBE};
            S_EMIT_SR:   w = '{OP_EMIT_SR,    C_ALWAYS,     S_IDLE};
            default:     w = '{OP_NOP,        C_ALWAYS,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sort_dedup_binary_search_core.sv -----
// ----------------------------------------------------------------------------
// sort_dedup_binary_search_core
// Loads a set of signed values, sorts and deduplicates it, then answers
// binary-search queries over the unique values.
// ----------------------------------------------------------------------------
// A microcoded sequencer steps a store with one read and one write port
// through every operation, one control word per cycle unless stalled on
// either channel, and one item is handled at a time. A load that is not
// last is accepted, dispatched and written. A last load of n stored values
// then runs the bubble sort over them, the dedup and the report.
// A search takes at most floor(log2(unique count))+1 probes, each a read
// and a compare, and ends when the key is found or the range is empty.
// Results sit in an output register, so the next input is taken while a
// result waits; a new result is posted only once the previous one has been
// transferred.
`default_nettype none

module sort_dedup_binary_search_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sdbs_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sdbs_pkg::out_item_t      out_data
);

    sdbs_pkg::ctrl_t   ctrl;
    sdbs_pkg::status_t status;

    sdbs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    sdbs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_data   (in_data),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Input is taken only at the idle step of the program
    assign in_ready = (ctrl.op == sdbs_pkg::OP_ACCEPT);

endmodule

`default_nettype wire

// ----- hw/rtl/sdbs_ram.sv -----
// ----------------------------------------------------------------------------
// sdbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sdbs_seq.sv -----
// ----------------------------------------------------------------------------
// sdbs_seq
// Microcode sequencer: step counter, program ROM, jump and stall logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbs_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire sdbs_pkg::status_t status,
    output sdbs_pkg::ctrl_t       ctrl
);

    logic [sdbs_pkg::STEP_W-1:0] upc_reg;
    logic [sdbs_pkg::STEP_W-1:0] upc_next;
    sdbs_pkg::ucode_t            uw;
    logic                        stall;
    logic                        take;

    assign uw = sdbs_pkg::ucode_rom(upc_reg);

    // Hold the step while waiting on either channel
    always_comb
    begin
        stall = ((uw.op == sdbs_pkg::OP_ACCEPT) && !in_valid) ||
                (((uw.op == sdbs_pkg::OP_EMIT_SET) || (uw.op == sdbs_pkg::OP_EMIT_SR)) &&
                 status.out_busy);
    end

    // Jump condition select
    always_comb
    begin
        unique case (uw.cond)
            sdbs_pkg::C_NEVER:      take = 1'b0;
            sdbs_pkg::C_ALWAYS:     take = 1'b1;
            sdbs_pkg::C_IS_SEARCH:  take = status.is_search;
            sdbs_pkg::C_NOT_LAST:   take = status.not_last;
            sdbs_pkg::C_P_LE1:      take = status.p_le1;
            sdbs_pkg::C_MORE_PAIRS: take = status.more_pairs;
            sdbs_pkg::C_DD_MORE:    take = status.dd_more;
            sdbs_pkg::C_SR_EMPTY:   take = status.sr_empty;
            sdbs_pkg::C_NOT_HIT:    take = status.not_hit;
            default:                take = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        if (stall)
        begin
            upc_next = upc_reg;
        end
        else if (take)
        begin
            upc_next = uw.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= sdbs_pkg::S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl.op = uw.op;
    assign ctrl.en = !stall;

endmodule

`default_nettype wire

// ----- hw/rtl/sdbs_datapath.sv -----
// ----------------------------------------------------------------------------
// sdbs_datapath
// Value store, index counters, comparators and output register, driven one
// action per cycle by the sequencer while it is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbs_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sdbs_pkg::ctrl_t    ctrl,
    input  wire sdbs_pkg::in_item_t in_data,
    input  wire logic               out_ready,
    output sdbs_pkg::status_t       status,
    output logic                    out_valid,
    output sdbs_pkg::out_item_t     out_data
);

    localparam int DW = sdbs_pkg::DATA_W;
    localparam int IW = sdbs_pkg::IDX_W;
    localparam int CW = sdbs_pkg::CNT_W;

    // Control state
    logic          op_reg,       op_next;
    logic          last_reg,     last_next;
    logic [CW-1:0] cnt_reg,      cnt_next;
    logic [CW-1:0] dist_reg,     dist_next;
    logic          complete_reg, complete_next;
    logic          ovf_reg,      ovf_next;
    logic [CW-1:0] p_reg,        p_next;
    logic [CW-1:0] j_reg,        j_next;
    logic [CW-1:0] w_reg,        w_next;
    logic [CW-1:0] lo_reg,       lo_next;
    logic [CW-1:0] hi_reg,       hi_next;
    logic          found_reg,    found_next;
    logic          out_valid_reg, out_valid_next;

    // Payload
    logic [DW-1:0]       key_reg, key_next;
    logic [DW-1:0]       x_reg,   x_next;
    logic [IW-1:0]       mid_reg, mid_next;
    sdbs_pkg::out_item_t out_data_reg, out_data_next;

    // Store ports
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    // Derived values
    logic [CW-1:0] eff_cnt;
    logic          has_room;
    logic [CW-1:0] j_inc;
    logic [CW:0]   j_plus2;
    logic [CW-1:0] p_dec;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid_c;
    logic          less_rx;
    logic          less_rk;
    logic          keep;

    sdbs_ram #(
        .WIDTH (DW),
        .DEPTH (sdbs_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Index arithmetic and compares
    always_comb
    begin
        eff_cnt  = complete_reg ? '0 : cnt_reg;
        has_room = eff_cnt < CW'(sdbs_pkg::DEPTH);
        j_inc    = j_reg + 1'b1;
        j_plus2  = {1'b0, j_reg} + (CW+1)'(2);
        p_dec    = p_reg - 1'b1;
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid_c    = mid_sum[CW:1];
        less_rx  = $signed(ram_rdata) < $signed(x_reg);
        less_rk  = $signed(ram_rdata) < $signed(key_reg);
        keep     = (j_reg == '0) || (ram_rdata != x_reg);
    end

    // Flags for the sequencer
    always_comb
    begin
        status.is_search  = (op_reg == sdbs_pkg::OPC_SEARCH);
        status.not_last   = !last_reg;
        status.p_le1      = (p_reg <= CW'(1));
        status.more_pairs = (j_plus2 < {1'b0, p_reg});
        status.dd_more    = ({1'b0, j_inc} < {1'b0, cnt_reg}) && (j_inc != '0);
        status.sr_empty   = (lo_reg >= hi_reg);
        status.not_hit    = (ram_rdata != key_reg);
        status.out_busy   = out_valid_reg && !out_ready;
    end

    // Store address and write select
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = j_reg[IW-1:0];
        ram_wdata = x_reg;
        ram_raddr = '0;
        unique case (ctrl.op)
            sdbs_pkg::OP_LOAD:
            begin
                ram_we    = has_room;
                ram_waddr = eff_cnt[IW-1:0];
                ram_wdata = key_reg;
            end
            sdbs_pkg::OP_PASS_X:
            begin
                ram_raddr = j_inc[IW-1:0];
            end
            sdbs_pkg::OP_BUBBLE:
            begin
                ram_we    = 1'b1;
                ram_wdata = less_rx ? ram_rdata : x_reg;
                ram_raddr = j_plus2[IW-1:0];
            end
            sdbs_pkg::OP_PASS_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = p_dec[IW-1:0];
            end
            sdbs_pkg::OP_DD_STEP:
            begin
                ram_we    = keep;
                ram_waddr = w_reg[IW-1:0];
                ram_wdata = ram_rdata;
                ram_raddr = j_inc[IW-1:0];
            end
            sdbs_pkg::OP_SR_PROBE:
            begin
                ram_raddr = mid_c[IW-1:0];
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
        ram_we = ram_we && ctrl.en;
    end

    // Register updates per action
    always_comb
    begin
        op_next        = op_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        dist_next      = dist_reg;
        complete_next  = complete_reg;
        ovf_next       = ovf_reg;
        p_next         = p_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        found_next     = found_reg;
        key_next       = key_reg;
        x_next         = x_reg;
        mid_next       = mid_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (ctrl.en)
        begin
            unique case (ctrl.op)
                sdbs_pkg::OP_ACCEPT:
                begin
                    op_next   = in_data.opcode;
                    last_next = in_data.last_of_set;
                    key_next  = in_data.data_value[DW-1:0];
                end
                sdbs_pkg::OP_LOAD:
                begin
                    // First load after a finished set starts a new one
                    if (complete_reg)
                    begin
                        dist_next     = '0;
                        complete_next = 1'b0;
                        ovf_next      = 1'b0;
                    end
                    if (has_room)
                    begin
                        cnt_next = eff_cnt + 1'b1;
                    end
                    else
                    begin
                        cnt_next = eff_cnt;
                        ovf_next = 1'b1;
                    end
                end
                sdbs_pkg::OP_SORT_INIT:
                begin
                    p_next = cnt_reg;
                end
                sdbs_pkg::OP_PASS_START:
                begin
                    j_next = '0;
                end
                sdbs_pkg::OP_PASS_X:
                begin
                    x_next = ram_rdata;
                end
                sdbs_pkg::OP_BUBBLE:
                begin
                    // x carries the running maximum of the pass
                    if (!less_rx)
                    begin
                        x_next = ram_rdata;
                    end
                    j_next = j_inc;
                end
                sdbs_pkg::OP_PASS_END:
                begin
                    p_next = p_dec;
                end
                sdbs_pkg::OP_DD_INIT:
                begin
                    j_next = '0;
                    w_next = '0;
                end
                sdbs_pkg::OP_DD_STEP:
                begin
                    if (keep)
                    begin
                        w_next = w_reg + 1'b1;
                        x_next = ram_rdata;
                    end
                    j_next = j_inc;
                end
                sdbs_pkg::OP_SET_DONE:
                begin
                    dist_next     = w_reg;
                    complete_next = 1'b1;
                end
                sdbs_pkg::OP_EMIT_SET:
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.result_kind   = sdbs_pkg::KIND_SET;
                    out_data_next.found         = 1'b0;
                    out_data_next.position      = '0;
                    out_data_next.unique_count  = sdbs_pkg::UNIQ_W'(dist_reg);
                    out_data_next.overflowed    = ovf_reg;
                end
                sdbs_pkg::OP_SR_INIT:
                begin
                    lo_next    = '0;
                    hi_next    = dist_reg;
                    found_next = 1'b0;
                end
                sdbs_pkg::OP_SR_PROBE:
                begin
                    mid_next = mid_c[IW-1:0];
                end
                sdbs_pkg::OP_SR_CMP:
                begin
                    // Half-open range [lo, hi)
                    if (ram_rdata == key_reg)
                    begin
                        found_next = 1'b1;
                    end
                    else if (less_rk)
                    begin
                        lo_next = CW'(mid_reg) + 1'b1;
                    end
                    else
                    begin
                        hi_next = CW'(mid_reg);
                    end
                end
                sdbs_pkg::OP_EMIT_SR:
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.result_kind   = sdbs_pkg::KIND_SEARCH;
                    out_data_next.found         = found_reg;
                    out_data_next.position      = found_reg ? sdbs_pkg::POS_W'(mid_reg) : '0;
                    out_data_next.unique_count  = sdbs_pkg::UNIQ_W'(dist_reg);
                    out_data_next.overflowed    = ovf_reg;
                end
                default:
                begin
                    out_data_next = out_data_reg;
                end
            endcase
        end
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= sdbs_pkg::OPC_LOAD;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            dist_reg      <= '0;
            complete_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            p_reg         <= '0;
            j_reg         <= '0;
            w_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_reg        <= op_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            dist_reg      <= dist_next;
            complete_reg  <= complete_next;
            ovf_reg       <= ovf_next;
            p_reg         <= p_next;
            j_reg         <= j_next;
            w_reg         <= w_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        x_reg        <= x_next;
        mid_reg      <= mid_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sdbs_checker.sv -----
// ----------------------------------------------------------------------------
// sdbs_checker
// Port-level checks of the sort, dedup and search core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sdbs_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire sdbs_pkg::out_item_t out_data
);

    // A set report never carries a search answer
    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.result_kind == sdbs_pkg::KIND_SET)) |->
        (!out_data.found && (out_data.position == '0)))
        else $error("set report carries search fields");

    // A hit points inside the unique list
    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.found) |->
        (sdbs_pkg::UNIQ_W'(out_data.position) < out_data.unique_count))
        else $error("hit position beyond unique count");

    // Unique count never exceeds the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.unique_count <= sdbs_pkg::UNIQ_W'(sdbs_pkg::DEPTH)))
        else $error("unique count beyond store depth");

    // After a transfer in, the core is not ready in the cycle after it
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a transfer");

    // A waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed before transfer");

endmodule

bind sort_dedup_binary_search_core sdbs_checker u_sdbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
